// ----- design/u8d_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants of the UTF-8 to UTF-16 stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

	localparam logic [20:0] REPL_CP      = 21'h00FFFD;
	localparam logic [20:0] BMP_MAX      = 21'h00FFFF;
	localparam logic [20:0] SUPP_BASE    = 21'h010000;
	localparam logic [15:0] HI_SURR_BASE = 16'hD800;
	localparam logic [5:0]  LO_SURR_TAG  = 6'b110111;
	localparam int unsigned QUEUE_DEPTH  = 4;
	localparam int unsigned QUEUE_AW     = 2;

	// tail kinds of a queued command
	localparam logic [1:0] TAIL_NONE = 2'd0;
	localparam logic [1:0] TAIL_ONE  = 2'd1;
	localparam logic [1:0] TAIL_PAIR = 2'd2;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [20:0] code_unit;
		logic        run_last;
		logic        string_last;
	} out_item_t;

	// one accepted byte, classified: replacement count, then an optional tail
	typedef struct packed {
		logic [1:0]  repl;
		logic [1:0]  tail_n;
		logic [20:0] unit_a;
		logic [9:0]  unit_b;
		logic        last;
	} cmd_t;

endpackage

// ----- design/u8d_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_front
// Byte classifier: tracks the open sequence and turns each byte into a command.
// ----------------------------------------------------------------------------
module u8d_front (
	input  logic              clk,
	input  logic              arst_n,
	input  u8d_pkg::in_item_t in_data,
	input  logic              accept,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	output logic              cmd_valid,
	output u8d_pkg::cmd_t     cmd
);

	logic [7:0]  lead_q, lead_n;
	logic [2:0]  need_q, need_n;
	logic [1:0]  held_q, held_n;
	logic [17:0] bits_q, bits_n;
	logic        mode_q;

	logic [7:0]  b;
	logic        last;
	logic        cont;
	logic [2:0]  fresh_need;
	logic        fresh_open;
	logic [20:0] fresh_val;
	logic [20:0] cp;
	logic [20:0] d;
	logic        split;

	always_comb begin
		b    = in_data.in_byte;
		last = in_data.last_byte;
		cont = (b[7:6] == 2'b10);

		if (b[7:5] == 3'b110) begin
			fresh_need = 3'd2;
		end else if (b[7:4] == 4'hE) begin
			fresh_need = 3'd3;
		end else if (b[7:3] == 5'h1E) begin
			fresh_need = 3'd4;
		end else begin
			fresh_need = 3'd0;
		end
		fresh_open = (fresh_need != 3'd0) && !last;
		fresh_val  = b[7] ? u8d_pkg::REPL_CP : {13'd0, b};

		case (need_q)
			3'd2: cp = {10'd0, lead_q[4:0], b[5:0]};
			3'd3: cp = {5'd0, lead_q[3:0], bits_q[5:0], b[5:0]};
			default: cp = {lead_q[2:0], bits_q[11:0], b[5:0]};
		endcase
		d     = cp - u8d_pkg::SUPP_BASE;
		split = mode_q && (cp > u8d_pkg::BMP_MAX);

		lead_n = lead_q;
		need_n = need_q;
		held_n = held_q;
		bits_n = bits_q;
		cmd    = '0;
		cmd.tail_n = u8d_pkg::TAIL_NONE;

		if ((need_q != 3'd0) && cont) begin
			if (({1'b0, held_q} + 3'd2) >= need_q) begin
				lead_n = '0;
				need_n = '0;
				held_n = '0;
				bits_n = '0;
				if (split) begin
					cmd.tail_n = u8d_pkg::TAIL_PAIR;
					cmd.unit_a = {5'd0, u8d_pkg::HI_SURR_BASE | {5'd0, d[20:10]}};
				end else begin
					cmd.tail_n = u8d_pkg::TAIL_ONE;
					cmd.unit_a = cp;
				end
				cmd.unit_b = d[9:0];
			end else if (last) begin
				lead_n   = '0;
				need_n   = '0;
				held_n   = '0;
				bits_n   = '0;
				cmd.repl = held_q + 2'd2;
			end else begin
				held_n = held_q + 2'd1;
				bits_n = {bits_q[11:0], b[5:0]};
			end
		end else begin
			cmd.repl = (need_q != 3'd0) ? (held_q + 2'd1) : 2'd0;
			if (fresh_open) begin
				lead_n = b;
				need_n = fresh_need;
				held_n = '0;
				bits_n = '0;
			end else begin
				lead_n     = '0;
				need_n     = '0;
				held_n     = '0;
				bits_n     = '0;
				cmd.tail_n = u8d_pkg::TAIL_ONE;
				cmd.unit_a = fresh_val;
			end
		end

		cmd.last  = last;
		cmd_valid = accept && ((cmd.repl != 2'd0) || (cmd.tail_n != u8d_pkg::TAIL_NONE));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= '0;
			need_q <= '0;
			held_q <= '0;
			bits_q <= '0;
			mode_q <= 1'b1;
		end else begin
			if (accept) begin
				lead_q <= lead_n;
				need_q <= need_n;
				held_q <= held_n;
				bits_q <= bits_n;
			end
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
		end
	end

endmodule

// ----- design/u8d_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_fifo
// Short command queue between the classifier and the unit emitter.
// ----------------------------------------------------------------------------
module u8d_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  u8d_pkg::cmd_t wr_data,
	input  logic          rd_en,
	output u8d_pkg::cmd_t rd_data,
	output logic          full,
	output logic          empty
);

	u8d_pkg::cmd_t                  mem_q [u8d_pkg::QUEUE_DEPTH];
	logic [u8d_pkg::QUEUE_AW-1:0]   wr_ptr_q;
	logic [u8d_pkg::QUEUE_AW-1:0]   rd_ptr_q;
	logic [u8d_pkg::QUEUE_AW:0]     count_q;

	assign full    = (count_q == (u8d_pkg::QUEUE_AW+1)'(u8d_pkg::QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- design/u8d_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_back
// Unit emitter: expands each queued command into code units, one a cycle while pop is high.
// ----------------------------------------------------------------------------
module u8d_back (
	input  logic               clk,
	input  logic               arst_n,
	input  u8d_pkg::cmd_t      head,
	input  logic               head_empty,
	output logic               head_pop,
	output u8d_pkg::out_item_t out_data,
	output logic               empty,
	input  logic               pop
);

	logic                 out_valid_q;
	u8d_pkg::out_item_t   out_q;
	logic [1:0]           k_q;

	logic                 load;
	logic [2:0]           total;
	logic                 is_end;
	logic [20:0]          unit;

	always_comb begin
		load   = !head_empty && (!out_valid_q || pop);
		total  = {1'b0, head.repl} + {1'b0, head.tail_n};
		is_end = ({1'b0, k_q} == (total - 3'd1));
		if (k_q < head.repl) begin
			unit = u8d_pkg::REPL_CP;
		end else if ((head.tail_n == u8d_pkg::TAIL_PAIR) && (k_q != head.repl)) begin
			unit = {5'd0, u8d_pkg::LO_SURR_TAG, head.unit_b};
		end else begin
			unit = head.unit_a;
		end
		head_pop = load && is_end;
	end

	assign out_data = out_q;
	assign empty    = !out_valid_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.code_unit   <= unit;
			out_q.run_last    <= is_end;
			out_q.string_last <= is_end && head.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			k_q         <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				k_q         <= is_end ? 2'd0 : (k_q + 2'd1);
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- design/utf8_to_utf16_stream_decoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_stream_decoder_core
// Streaming UTF-8 decoder with optional UTF-16 surrogate splitting.
// ----------------------------------------------------------------------------
// usage:
//   input side is a queue write port: a byte transaction is taken when push
//   is high and full is low; last_byte marks the final byte of a string
//   result side is a queue read port: the oldest code unit sits on out_data
//   while empty is low and leaves when pop is high
//   cfg_we with cfg_wdata sets utf16 mode (1 at reset); write it while idle
// path: a taken byte's command is written to the command queue, then loaded into the output register
// throughput: one byte per cycle while full is low and one code unit per cycle while pop is high; a byte giving
//   several units (up to four) sends them one after another on the result side,
//   the four-entry command queue absorbs the burst
// reset: the open sequence is dropped, queue and output register empty
// stall: when pop stays low the output register holds, the queue fills and
//   full rises; nothing is lost
// ----------------------------------------------------------------------------
module utf8_to_utf16_stream_decoder_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  u8d_pkg::in_item_t  in_data,
	output logic               empty,
	input  logic               pop,
	output u8d_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic               cfg_wdata
);

	logic          accept;
	logic          cmd_valid;
	u8d_pkg::cmd_t cmd;
	u8d_pkg::cmd_t head;
	logic          head_empty;
	logic          head_pop;

	assign accept = push && !full;

	u8d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.accept    (accept),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd_valid (cmd_valid),
		.cmd       (cmd)
	);

	u8d_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_valid),
		.wr_data (cmd),
		.rd_en   (head_pop),
		.rd_data (head),
		.full    (full),
		.empty   (head_empty)
	);

	u8d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_empty (head_empty),
		.head_pop   (head_pop),
		.out_data   (out_data),
		.empty      (empty),
		.pop        (pop)
	);

endmodule

// ----- design/u8d_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module u8d_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               full,
	input logic               empty,
	input logic               pop,
	input u8d_pkg::out_item_t out_data
);

	// reset empties both sides
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> (empty && !full))
		else $error("decoder not empty in reset");

	// a stalled transaction holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_data)))
		else $error("result changed while stalled");

	// end of string only on the last unit of a byte
	a_string_run: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_data.string_last) |-> out_data.run_last)
		else $error("string_last without run_last");

	// a unit that is not last for its byte is a replacement or in the surrogate range
	a_inner_unit: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !out_data.run_last) |->
		((out_data.code_unit == u8d_pkg::REPL_CP) ||
		 (out_data.code_unit[20:11] == 10'b0000011011)))
		else $error("unexpected inner code unit");

endmodule

bind utf8_to_utf16_stream_decoder_core u8d_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.full     (full),
	.empty    (empty),
	.pop      (pop),
	.out_data (out_data)
);

// ----- dv/utf8_to_utf16_stream_decoder_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_stream_decoder_core_tb
// Self-checking bench for the UTF-8 stream decoder. Byte transactions come
// from a queue of pending bytes. The first phase is a directed set of edge
// and error cases. The later phases send random strings: mostly well-formed
// characters of every length, plus truncated sequences, lone continuation
// bytes and invalid leads. Each later phase sets utf16 mode while the block
// is idle, and each uses its own pattern of sender gaps and receiver stalls.
// A bit-accurate predictor turns each accepted byte into the code units
// expected from it, and every popped unit is checked field by field.
// ----------------------------------------------------------------------------
module utf8_to_utf16_stream_decoder_core_tb;

	localparam int IDLE_NONE     = 0;
	localparam int IDLE_SENDER   = 1;
	localparam int IDLE_RECEIVER = 2;
	localparam int IDLE_BOTH     = 3;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               push      = 1'b0;
	logic               full;
	u8d_pkg::in_item_t  in_data   = '0;
	logic               empty;
	logic               pop       = 1'b0;
	u8d_pkg::out_item_t out_data;
	logic               cfg_we    = 1'b0;
	logic               cfg_wdata = 1'b0;

	u8d_pkg::in_item_t  bytes_to_send[$];
	u8d_pkg::out_item_t units_due[$];
	logic [20:0]        unit_buf[$];
	int                 error_count = 0;
	int                 bytes_queued = 0;
	int                 idle_mode = IDLE_NONE;
	int                 hold_left = 0;

	// decoder state as seen from outside
	logic        utf16_on = 1'b1;
	logic [7:0]  seq_lead = '0;
	logic [2:0]  seq_need = '0;
	logic [1:0]  seq_held = '0;
	logic [17:0] seq_bits = '0;

	utf8_to_utf16_stream_decoder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_data   (in_data),
		.empty     (empty),
		.pop       (pop),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void close_sequence();
		seq_lead = '0;
		seq_need = '0;
		seq_held = '0;
		seq_bits = '0;
	endfunction

	function automatic void flush_sequence(int extra);
		repeat (1 + int'(seq_held) + extra) unit_buf.push_back(u8d_pkg::REPL_CP);
		close_sequence();
	endfunction

	function automatic void start_fresh(logic [7:0] b, logic last);
		logic [2:0] need;
		need = 3'd0;
		if (b < 8'h80) begin
			unit_buf.push_back({13'd0, b});
			return;
		end
		if (b[7:5] == 3'b110)
			need = 3'd2;
		else if (b[7:4] == 4'b1110)
			need = 3'd3;
		else if (b[7:3] == 5'b11110)
			need = 3'd4;
		if (need == 3'd0 || last) begin
			unit_buf.push_back(u8d_pkg::REPL_CP);
		end else begin
			seq_lead = b;
			seq_need = need;
			seq_held = '0;
			seq_bits = '0;
		end
	endfunction

	function automatic void decode_byte(u8d_pkg::in_item_t it);
		logic [7:0]         b;
		logic [7:0]         lead_mask;
		logic [31:0]        cp32;
		logic [20:0]        cp;
		logic [20:0]        d;
		int                 nbits;
		u8d_pkg::out_item_t o;
		b = it.in_byte;
		unit_buf.delete();
		if (seq_need != 3'd0) begin
			if (b[7:6] == 2'b10) begin
				if (int'(seq_held) + 2 >= int'(seq_need)) begin
					nbits = 6 * (int'(seq_need) - 1);
					lead_mask = (seq_need == 3'd2) ? 8'h1F :
						(seq_need == 3'd3) ? 8'h0F : 8'h07;
					cp32 = ({24'd0, seq_lead & lead_mask} << nbits) |
						{8'd0, seq_bits, b[5:0]};
					cp = cp32[20:0];
					close_sequence();
					if (utf16_on && cp > u8d_pkg::BMP_MAX) begin
						d = cp - u8d_pkg::SUPP_BASE;
						unit_buf.push_back({5'd0, u8d_pkg::HI_SURR_BASE | {5'd0, d[20:10]}});
						unit_buf.push_back({5'd0, u8d_pkg::LO_SURR_TAG, d[9:0]});
					end else begin
						unit_buf.push_back(cp);
					end
				end else if (it.last_byte) begin
					flush_sequence(1);
				end else begin
					seq_bits = {seq_bits[11:0], b[5:0]};
					seq_held = seq_held + 2'd1;
				end
			end else begin
				flush_sequence(0);
				start_fresh(b, it.last_byte);
			end
		end else begin
			start_fresh(b, it.last_byte);
		end
		foreach (unit_buf[k]) begin
			o.code_unit   = unit_buf[k];
			o.run_last    = (k == unit_buf.size() - 1);
			o.string_last = o.run_last & it.last_byte;
			units_due.push_back(o);
		end
	endfunction

	function automatic bit sender_rests();
		if (idle_mode == IDLE_SENDER)
			return $urandom_range(99) < 65;
		if (idle_mode == IDLE_BOTH)
			return $urandom_range(99) < 14;
		return 1'b0;
	endfunction

	function automatic bit receiver_rests();
		if (idle_mode == IDLE_RECEIVER)
			return $urandom_range(99) < 65;
		if (idle_mode == IDLE_BOTH)
			return $urandom_range(99) < 14;
		return 1'b0;
	endfunction

	// byte driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				decode_byte(in_data);
			if (!push || !full) begin
				if (bytes_to_send.size() != 0 && !sender_rests()) begin
					in_data <= bytes_to_send.pop_front();
					push    <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_left > 0)
			hold_left <= hold_left - 1;
	end

	// code unit monitor
	always @(posedge clk) begin
		u8d_pkg::out_item_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (units_due.size() == 0) begin
					$display("%0t: unexpected code unit transaction, actual %h", $time, out_data);
					error_count++;
				end else begin
					want = units_due.pop_front();
					if (out_data.code_unit !== want.code_unit) begin
						$display("%0t: code_unit mismatch, expected %h actual %h",
							$time, want.code_unit, out_data.code_unit);
						error_count++;
					end
					if (out_data.run_last !== want.run_last) begin
						$display("%0t: run_last mismatch, expected %b actual %b",
							$time, want.run_last, out_data.run_last);
						error_count++;
					end
					if (out_data.string_last !== want.string_last) begin
						$display("%0t: string_last mismatch, expected %b actual %b",
							$time, want.string_last, out_data.string_last);
						error_count++;
					end
				end
			end
			pop <= (hold_left == 0) && !receiver_rests();
		end
	end

	task automatic put_byte(logic [7:0] b, logic last);
		u8d_pkg::in_item_t it;
		it.in_byte   = b;
		it.last_byte = last;
		bytes_to_send.push_back(it);
		bytes_queued++;
	endtask

	// one random character, well-formed or not
	task automatic put_char(logic last);
		logic [20:0] cp;
		logic [7:0]  seq[$];
		int          len;
		int          keep;
		int          r;
		r = $urandom_range(99);
		seq.delete();
		if (r < 80) begin
			len = $urandom_range(1, 4);
			cp  = 21'($urandom());
			case (len)
				1: seq = '{{1'b0, cp[6:0]}};
				2: seq = '{{3'b110, cp[10:6]}, {2'b10, cp[5:0]}};
				3: seq = '{{4'b1110, cp[15:12]}, {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
				default: seq = '{{5'b11110, cp[20:18]}, {2'b10, cp[17:12]},
					{2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
			endcase
			// truncated sequence
			if (r >= 70 && len > 1) begin
				keep = $urandom_range(1, len - 1);
				while (seq.size() > keep)
					void'(seq.pop_back());
			end
		end else if (r < 88) begin
			seq.push_back(8'($urandom()));
		end else if (r < 94) begin
			seq.push_back(8'($urandom_range(8'h80, 8'hBF)));
		end else begin
			seq.push_back(8'($urandom_range(8'hF8, 8'hFF)));
		end
		foreach (seq[k])
			put_byte(seq[k], last && (k == seq.size() - 1));
	endtask

	task automatic put_random_bytes(int target);
		int n;
		bytes_queued = 0;
		while (bytes_queued < target) begin
			n = $urandom_range(1, 6);
			for (int c = 0; c < n; c++)
				put_char(c == n - 1);
		end
	endtask

	task automatic wait_idle();
		while (bytes_to_send.size() != 0 || push || units_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic run_phase(logic mode, int idling, int target, int hold);
		wait_idle();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (hold > 0)
			hold_left <= hold;
		@(negedge clk);
		utf16_on  = mode;
		idle_mode = idling;
		put_random_bytes(target);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// ascii extremes
		put_byte(8'h00, 1'b0);
		put_byte(8'h7F, 1'b1);
		// two and three byte maxima
		put_byte(8'hDF, 1'b0);
		put_byte(8'hBF, 1'b0);
		put_byte(8'hEF, 1'b0);
		put_byte(8'hBF, 1'b0);
		put_byte(8'hBF, 1'b1);
		// first supplementary point and the top of the four byte range
		put_byte(8'hF0, 1'b0);
		put_byte(8'h90, 1'b0);
		put_byte(8'h80, 1'b0);
		put_byte(8'h80, 1'b0);
		put_byte(8'hF7, 1'b0);
		put_byte(8'hBF, 1'b0);
		put_byte(8'hBF, 1'b0);
		put_byte(8'hBF, 1'b1);
		// lone continuation, invalid lead, lead as final byte
		put_byte(8'h80, 1'b0);
		put_byte(8'hFF, 1'b0);
		put_byte(8'hC2, 1'b1);
		// string ends inside a sequence
		put_byte(8'hF0, 1'b0);
		put_byte(8'h90, 1'b0);
		put_byte(8'h80, 1'b1);
		// sequence broken by an ascii byte
		put_byte(8'hE2, 1'b0);
		put_byte(8'h82, 1'b0);
		put_byte(8'h41, 1'b1);

		run_phase(1'b0, IDLE_NONE, 35, 0);
		run_phase(1'b1, IDLE_SENDER, 35, 0);
		run_phase(1'b0, IDLE_RECEIVER, 45, 80);
		run_phase(1'b1, IDLE_BOTH, 55, 0);

		wait_idle();
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#400000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
design/u8d_pkg.sv
design/u8d_front.sv
design/u8d_fifo.sv
design/u8d_back.sv
design/utf8_to_utf16_stream_decoder_core.sv
design/u8d_checker.sv
dv/utf8_to_utf16_stream_decoder_core_tb.sv
